@@ hw/rtl/tgsdp_pkg.sv @@
// ---------------------------------------------------------------------------
// tgsdp_pkg: shared definitions for the two-group selection block
// Table geometry, field widths, register indexes and the saturating add
// used by the table update.
// ---------------------------------------------------------------------------
package tgsdp_pkg;

	// Table geometry: (MAX_A+1) rows of (MAX_B+1) cells.
	localparam int MAX_A       = 16;
	localparam int MAX_B       = 16;
	localparam int WEIGHT_BITS = 16;

	localparam int ROW_LEN    = MAX_B + 1;
	localparam int TBL_DEPTH  = (MAX_A + 1) * (MAX_B + 1);
	localparam int TBL_ADDR_W = $clog2(TBL_DEPTH);
	localparam int IDX_W      = $clog2(MAX_A + 1);
	localparam int JDX_W      = $clog2(MAX_B + 1);

	// Field widths of the streams and registers.
	localparam int W_IN       = 16;
	localparam int CELL_W     = 21;
	localparam int CNT_W      = 5;
	localparam int SEEN_W     = 6;
	localparam int SEEN_MAX   = 63;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 24;

	localparam logic [CELL_W-1:0] CELL_MAX = {CELL_W{1'b1}};
	localparam logic [W_IN-1:0]   W_MASK   = W_IN'((64'd1 << WEIGHT_BITS) - 64'd1);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_A = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_B = 1'b1;

	// Add a weight to a cell value, clamped at the largest cell value.
	function automatic logic [CELL_W-1:0] sat_add(input logic [CELL_W-1:0] x,
		input logic [W_IN-1:0] w);
		logic [CELL_W:0] sum;
		sum = {1'b0, x} + (CELL_W+1)'(w);
		return sum[CELL_W] ? CELL_MAX : sum[CELL_W-1:0];
	endfunction

endpackage

@@ hw/rtl/tgsdp_ram.sv @@
// ---------------------------------------------------------------------------
// tgsdp_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module tgsdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/two_group_selection_dp.sv @@
// ---------------------------------------------------------------------------
// two_group_selection_dp: best total for a two-group item selection
// Each item is put in group A, group B or skipped; a table of best totals per
// (A used, B used) is swept once per item, and on the last item the total for
// exactly count_a A items and count_b B items (each clamped to the table size) is returned.
// ---------------------------------------------------------------------------
//
// Channel   Dir  Signals                          Content
// s_*       in   s_tvalid s_tready s_tdata s_tlast a_weight, b_weight, is_last
// m_*       out  m_tvalid m_tready m_tdata m_tuser best_total, status
// cfg_*     in   cfg_wen cfg_addr cfg_wdata        count_a, count_b
//
// After an item's transfer s_tready stays low while the whole table is swept,
// one read-modify-write of the table memory per cycle, and while the read
// pipeline drains; the next item is not taken until that sweep is done. A last
// item also loads the output register, after any time it waits for m_tready.
// Reset needs no clearing pass: the first item of a sequence reads every table
// cell as zero, and its sweep writes every cell.
// The output register holds its result while the next item is swept.
module two_group_selection_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_wen,
	input  logic [tgsdp_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [tgsdp_pkg::CNT_W-1:0]       cfg_wdata,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tgsdp_pkg::IN_DATA_W-1:0]   s_tdata,  // [15:0] a_weight, [31:16] b_weight
	input  logic                              s_tlast,  // is_last
	// Output stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tgsdp_pkg::OUT_DATA_W-1:0]  m_tdata,  // [20:0] best_total, [23:21] zero
	output logic                              m_tuser   // status
);

	import tgsdp_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_PUSH} state_t;

	state_t state_q;

	logic [CNT_W-1:0]      count_a_q, count_b_q;
	logic [SEEN_W-1:0]     seen_q;
	logic [W_IN-1:0]       wa_q, wb_q;
	logic                  last_q, zero_q;

	logic [IDX_W-1:0]      rd_i_q;
	logic [JDX_W-1:0]      rd_j_q;
	logic [TBL_ADDR_W-1:0] rd_addr_q;
	logic                  issue_done_q;
	logic                  rd_en;

	logic                  s1_valid_q;
	logic [IDX_W-1:0]      i_s1;
	logic [JDX_W-1:0]      j_s1;
	logic [TBL_ADDR_W-1:0] addr_s1;

	logic [CELL_W-1:0]     tbl_rdata, row_rdata;
	logic [CELL_W-1:0]     old_cur, left_q, cand_up, cand_left, new_val, cap_q;
	logic [CELL_W-1:0]     res_total_q, m_total_q;
	logic                  res_status_q, m_status_q, m_valid_q;

	logic [IDX_W-1:0]      na;
	logic [JDX_W-1:0]      nb;
	logic                  hit_now, s1_final, rd_final, out_free, short_seq;
	logic [CELL_W-1:0]     final_total;

	// Handshake outputs.
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_DATA_W'(m_total_q);
	assign m_tuser  = m_status_q;
	assign out_free = !m_valid_q || m_tready;

	// Counts clamped to the table size.
	assign na = (32'(count_a_q) > MAX_A) ? IDX_W'(MAX_A) : IDX_W'(count_a_q);
	assign nb = (32'(count_b_q) > MAX_B) ? JDX_W'(MAX_B) : JDX_W'(count_b_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q <= '0;
			count_b_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_COUNT_A: count_a_q <= cfg_wdata;
				REG_COUNT_B: count_b_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Read side of the sweep: one cell per cycle in ascending address order.
	assign rd_en    = (state_q == ST_SWEEP) && !issue_done_q;
	assign rd_final = (rd_i_q == IDX_W'(MAX_A)) && (rd_j_q == JDX_W'(MAX_B));

	// Table memory: one cell per entry, row-major.
	tgsdp_ram #(.WIDTH(CELL_W), .DEPTH(TBL_DEPTH)) u_tbl (
		.clk   (clk),
		.we    (s1_valid_q),
		.waddr (addr_s1),
		.wdata (new_val),
		.re    (rd_en),
		.raddr (rd_addr_q),
		.rdata (tbl_rdata)
	);

	// Row buffer: old values of the previous row, indexed by column.
	tgsdp_ram #(.WIDTH(CELL_W), .DEPTH(ROW_LEN)) u_row (
		.clk   (clk),
		.we    (s1_valid_q),
		.waddr (j_s1),
		.wdata (old_cur),
		.re    (rd_en),
		.raddr (rd_j_q),
		.rdata (row_rdata)
	);

	// Cell update from the old values above, to the left and in place.
	assign old_cur   = zero_q ? '0 : tbl_rdata;
	assign cand_up   = sat_add(row_rdata, wa_q);
	assign cand_left = sat_add(left_q, wb_q);

	always_comb begin
		new_val = old_cur;
		if ((i_s1 != '0) && (cand_up > new_val)) begin
			new_val = cand_up;
		end
		if ((j_s1 != '0) && (cand_left > new_val)) begin
			new_val = cand_left;
		end
	end

	// Result selection at the end of the sweep.
	assign hit_now     = (i_s1 == na) && (j_s1 == nb);
	assign s1_final    = (i_s1 == IDX_W'(MAX_A)) && (j_s1 == JDX_W'(MAX_B));
	assign final_total = hit_now ? new_val : cap_q;
	assign short_seq   = 32'(seen_q) < (32'(na) + 32'(nb));

	// Sequencer, sweep pipeline and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			seen_q       <= '0;
			rd_i_q       <= '0;
			rd_j_q       <= '0;
			rd_addr_q    <= '0;
			issue_done_q <= 1'b0;
			s1_valid_q   <= 1'b0;
			m_valid_q    <= 1'b0;
			last_q       <= 1'b0;
			zero_q       <= 1'b0;
		end else begin
			// Stage 1 follows the memory read.
			s1_valid_q <= rd_en;
			i_s1       <= rd_i_q;
			j_s1       <= rd_j_q;
			addr_s1    <= rd_addr_q;
			if (s1_valid_q) begin
				left_q <= old_cur;
				if (hit_now) begin
					cap_q <= new_val;
				end
			end

			// The output register empties on a transfer unless a new result loads.
			if (m_valid_q && m_tready && (state_q != ST_PUSH)) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						wa_q         <= s_tdata[W_IN-1:0] & W_MASK;
						wb_q         <= s_tdata[2*W_IN-1:W_IN] & W_MASK;
						last_q       <= s_tlast;
						zero_q       <= (seen_q == '0);
						seen_q       <= (seen_q == SEEN_W'(SEEN_MAX)) ? seen_q
							: seen_q + SEEN_W'(1);
						rd_i_q       <= '0;
						rd_j_q       <= '0;
						rd_addr_q    <= '0;
						issue_done_q <= 1'b0;
						state_q      <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (rd_en) begin
						rd_addr_q <= rd_addr_q + TBL_ADDR_W'(1);
						if (rd_j_q == JDX_W'(MAX_B)) begin
							rd_j_q <= '0;
							rd_i_q <= rd_i_q + IDX_W'(1);
						end else begin
							rd_j_q <= rd_j_q + JDX_W'(1);
						end
						if (rd_final) begin
							issue_done_q <= 1'b1;
						end
					end
					if (s1_valid_q && s1_final) begin
						if (last_q) begin
							res_status_q <= short_seq;
							res_total_q  <= short_seq ? '0 : final_total;
							seen_q       <= '0;
							state_q      <= ST_PUSH;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						m_valid_q  <= 1'b1;
						m_total_q  <= res_total_q;
						m_status_q <= res_status_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// No item is taken while the sweep pipeline still holds a cell.
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !s1_valid_q)
		else $error("input ready while a cell update is in flight");

	// A new result appears only out of the push state.
	a_result_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_PUSH))
		else $error("result loaded outside the push state");

	// The item count is already cleared while a result waits to be loaded.
	a_seen_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH) |-> (seen_q == '0))
		else $error("item count not cleared after a result");

	// The last cell of the sweep ends the reads.
	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s1_final) |-> !rd_en)
		else $error("table read issued after the last cell");

endmodule
